// ===== design/cci_pkg.sv =====
// ----------------------------------------------------------------------------
// Circle intersection package
// Shared defaults, register constants and the relation codes of the result.
// ----------------------------------------------------------------------------
package cci_pkg;

   localparam int COORD_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF   = 16;

   localparam int               TOL_WIDTH = 16;
   localparam logic [15:0]      TOL_RESET = 16'd66;

   typedef enum logic [2:0] {
      REL_INTERSECT     = 3'd0,
      REL_DISJOINT      = 3'd1,
      REL_FIRST_INSIDE  = 3'd2,
      REL_SECOND_INSIDE = 3'd3,
      REL_EQUAL         = 3'd4
   } rel_type;

endpackage

// ===== design/cci_sqrt.sv =====
// ----------------------------------------------------------------------------
// Pipelined integer square root
// One result bit per stage, remainder form, floor of the square root.
// ----------------------------------------------------------------------------
module cci_sqrt #(
   parameter int NW = 66,
   parameter int RW = 33
) (
   input  logic          clock,
   input  logic          en,
   input  logic [NW-1:0] rad,
   output logic [RW-1:0] root
);

   localparam int TW = ((NW > 2*RW+1) ? NW : 2*RW+1) + 1;

   logic [TW-1:0] rem_ff  [RW-1];
   logic [RW-1:0] root_ff [RW];

   for (genvar i = 0; i < RW; i++) begin : g_stage
      localparam int B = RW - 1 - i;
      logic [TW-1:0] rem_prev;
      logic [TW-1:0] trial;
      logic [RW-1:0] root_prev;
      logic          take;

      if (i == 0) begin : g_first
         assign rem_prev  = TW'(rad);
         assign root_prev = '0;
      end else begin : g_next
         assign rem_prev  = rem_ff[i-1];
         assign root_prev = root_ff[i-1];
      end

      // Trial subtrahend (2*root + 2^B) * 2^B.
      assign trial = (TW'(root_prev) << (B + 1)) + (TW'(1) << (2 * B));
      assign take  = rem_prev >= trial;

      always_ff @(posedge clock) begin
         if (en) begin
            root_ff[i] <= take ? (root_prev | (RW'(1) << B)) : root_prev;
         end
      end

      if (i < RW - 1) begin : g_rem
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[i] <= take ? (rem_prev - trial) : rem_prev;
            end
         end
      end
   end

   assign root = root_ff[RW-1];

endmodule

// ===== design/cci_div.sv =====
// ----------------------------------------------------------------------------
// Pipelined unsigned divider
// Restoring long division, one quotient bit per stage.
// ----------------------------------------------------------------------------
module cci_div #(
   parameter int NW = 67,
   parameter int DW = 34,
   parameter int QW = 31
) (
   input  logic          clock,
   input  logic          en,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic [QW-1:0] quo
);

   localparam int RW = (NW > DW + QW) ? NW : DW + QW;

   logic [RW-1:0] rem_ff [QW-1];
   logic [DW-1:0] den_ff [QW-1];
   logic [QW-1:0] quo_ff [QW];

   for (genvar i = 0; i < QW; i++) begin : g_stage
      localparam int B = QW - 1 - i;
      logic [RW-1:0] rem_prev;
      logic [DW-1:0] den_prev;
      logic [QW-1:0] quo_prev;
      logic [RW-1:0] shifted;
      logic          take;

      if (i == 0) begin : g_first
         assign rem_prev = RW'(num);
         assign den_prev = den;
         assign quo_prev = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[i-1];
         assign den_prev = den_ff[i-1];
         assign quo_prev = quo_ff[i-1];
      end

      assign shifted = RW'(den_prev) << B;
      assign take    = rem_prev >= shifted;

      always_ff @(posedge clock) begin
         if (en) begin
            quo_ff[i] <= take ? (quo_prev | (QW'(1) << B)) : quo_prev;
         end
      end

      if (i < QW - 1) begin : g_rem
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[i] <= take ? (rem_prev - shifted) : rem_prev;
               den_ff[i] <= den_prev;
            end
         end
      end
   end

   assign quo = quo_ff[QW-1];

endmodule

// ===== design/cci_delay.sv =====
// ----------------------------------------------------------------------------
// Pipeline delay line
// Carries a valid bit and side data alongside a multi-stage unit.
// ----------------------------------------------------------------------------
module cci_delay #(
   parameter int DEPTH = 4,
   parameter int W     = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         en,
   input  logic         in_valid,
   input  logic [W-1:0] in_data,
   output logic         out_valid,
   output logic [W-1:0] out_data
);

   logic [DEPTH-1:0] valid_ff;
   logic [W-1:0]     data_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
         for (int i = 1; i < DEPTH; i++) begin
            valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff[0] <= in_data;
         for (int i = 1; i < DEPTH; i++) begin
            data_ff[i] <= data_ff[i-1];
         end
      end
   end

   assign out_valid = valid_ff[DEPTH-1];
   assign out_data  = data_ff[DEPTH-1];

endmodule

// ===== design/circle_circle_intersection.sv =====
// ----------------------------------------------------------------------------
// Circle-circle intersection engine
// Classifies a pair of circles and returns the crossing points.
// ----------------------------------------------------------------------------
// Each req beat carries two circles (centers in signed fixed point, unsigned radii).
// Each rsp beat carries the relation code and, for crossing circles, the two
// crossing points relative to each center; the points are zero otherwise.
// The tolerance register is written through csr_we/csr_wdata; the user must write it only while idle (not enforced).
//
// The pipeline takes one beat per cycle while it is not stalled. Its depth is
// set mostly by the center-distance square root, the chord division (QW
// quotient bits, QW being the larger of COORD_WIDTH-1 and FRAC_BITS+1) and
// the half-chord square root, each resolving one bit a stage.
//
// Reset clears all valid bits and loads the tolerance with its default.
// When the receiver holds rsp_tready low with a beat waiting, the whole
// pipeline freezes and req_tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module circle_circle_intersection
   import cci_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = FRAC_BITS_DEF,
   localparam int REQ_W = ((6 * COORD_WIDTH - 2 + 7) / 8) * 8,
   localparam int RSP_W = ((8 * COORD_WIDTH + 3 + 7) / 8) * 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [TOL_WIDTH-1:0] csr_wdata,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // center0_x, center0_y, radius0, center1_x, center1_y, radius1
   input  logic [REQ_W-1:0]     req_tdata,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // relation, p0a_x, p0a_y, p0b_x, p0b_y, p1a_x, p1a_y, p1b_x, p1b_y
   output logic [RSP_W-1:0]     rsp_tdata
);

   localparam int CW   = COORD_WIDTH;
   localparam int F    = FRAC_BITS;
   localparam int DXW  = CW + 1;
   localparam int RRW  = CW - 1;
   localparam int SQW  = 2 * CW + 2;
   localparam int DSTW = CW + 1;
   localparam int R2W  = 2 * CW - 2;
   localparam int NUMW = 2 * CW + 3;
   localparam int TWDW = CW + 2;
   localparam int R0TW = 2 * CW + 1;
   localparam int QW   = (CW - 1 > F + 1) ? CW - 1 : F + 1;
   localparam int UNW  = DXW + F;
   localparam int UW   = F + 2;
   localparam int PRW  = UW + CW;
   localparam int SUMW = PRW + 1;
   localparam int SHW  = SUMW - F;
   localparam int FW   = SHW + 1;

   function automatic logic [CW-1:0] sat(input logic [FW-1:0] v);
      logic [CW-1:0] r;
      if ((&v[FW-1:CW-1]) || !(|v[FW-1:CW-1])) begin
         r = v[CW-1:0];
      end else if (v[FW-1]) begin
         r = {1'b1, {(CW-1){1'b0}}};
      end else begin
         r = {1'b0, {(CW-1){1'b1}}};
      end
      return r;
   endfunction

   logic en;
   logic [TOL_WIDTH-1:0] tol_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_RESET;
      end else if (csr_we) begin
         tol_ff <= csr_wdata;
      end
   end

   // The pipeline advances unless a finished beat is waiting on the receiver.
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   // ---------------------------------------------------------------- input
   logic signed [CW-1:0] in_c0x, in_c0y, in_c1x, in_c1y;
   logic [RRW-1:0]       in_r0, in_r1;

   assign in_c0x = req_tdata[CW-1:0];
   assign in_c0y = req_tdata[2*CW-1:CW];
   assign in_r0  = req_tdata[3*CW-2:2*CW];
   assign in_c1x = req_tdata[4*CW-2:3*CW-1];
   assign in_c1y = req_tdata[5*CW-2:4*CW-1];
   assign in_r1  = req_tdata[6*CW-3:5*CW-1];

   // Stage 1: center offset.
   logic                  v1_ff;
   logic signed [DXW-1:0] dx1_ff, dy1_ff;
   logic [RRW-1:0]        r0_1_ff, r1_1_ff;

   // Stage 2: squares.
   logic                  v2_ff;
   logic [SQW-1:0]        sqx2_ff, sqy2_ff;
   logic signed [DXW-1:0] dx2_ff, dy2_ff;
   logic [RRW-1:0]        r0_2_ff, r1_2_ff;
   logic [R2W-1:0]        r0sq2_ff, r1sq2_ff;
   logic [DXW-1:0]        dxm1, dym1;

   // Stage 3: squared distance.
   logic                  v3_ff;
   logic [SQW-1:0]        sum3_ff;
   logic signed [DXW-1:0] dx3_ff, dy3_ff;
   logic [RRW-1:0]        r0_3_ff, r1_3_ff;
   logic [R2W-1:0]        r0sq3_ff, r1sq3_ff;

   assign dxm1 = dx1_ff[DXW-1] ? DXW'(-dx1_ff) : DXW'(dx1_ff);
   assign dym1 = dy1_ff[DXW-1] ? DXW'(-dy1_ff) : DXW'(dy1_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_tvalid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dx1_ff   <= DXW'(in_c1x) - DXW'(in_c0x);
         dy1_ff   <= DXW'(in_c1y) - DXW'(in_c0y);
         r0_1_ff  <= in_r0;
         r1_1_ff  <= in_r1;

         sqx2_ff  <= dxm1 * dxm1;
         sqy2_ff  <= dym1 * dym1;
         dx2_ff   <= dx1_ff;
         dy2_ff   <= dy1_ff;
         r0_2_ff  <= r0_1_ff;
         r1_2_ff  <= r1_1_ff;
         r0sq2_ff <= r0_1_ff * r0_1_ff;
         r1sq2_ff <= r1_1_ff * r1_1_ff;

         sum3_ff  <= sqx2_ff + sqy2_ff;
         dx3_ff   <= dx2_ff;
         dy3_ff   <= dy2_ff;
         r0_3_ff  <= r0_2_ff;
         r1_3_ff  <= r1_2_ff;
         r0sq3_ff <= r0sq2_ff;
         r1sq3_ff <= r1sq2_ff;
      end
   end

   // ------------------------------------------------------ center distance
   localparam int PAW = 2 * DXW + 2 * RRW + 2 * R2W;

   logic [DSTW-1:0]       dist_a;
   logic                  va;
   logic [PAW-1:0]        pa_out;
   logic signed [DXW-1:0] dx_a, dy_a;
   logic [RRW-1:0]        r0_a, r1_a;
   logic [R2W-1:0]        r0sq_a, r1sq_a;

   cci_sqrt #(.NW(SQW), .RW(DSTW)) u_dist_sqrt (
      .clock (clock),
      .en    (en),
      .rad   (sum3_ff),
      .root  (dist_a)
   );

   cci_delay #(.DEPTH(DSTW), .W(PAW)) u_dist_delay (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v3_ff),
      .in_data   ({dx3_ff, dy3_ff, r0_3_ff, r1_3_ff, r0sq3_ff, r1sq3_ff}),
      .out_valid (va),
      .out_data  (pa_out)
   );

   assign {dx_a, dy_a, r0_a, r1_a, r0sq_a, r1sq_a} = pa_out;

   // --------------------------------------------------------- classification
   logic [RRW-1:0] rdiff_a;
   assign rdiff_a = (r0_a > r1_a) ? (r0_a - r1_a) : (r1_a - r0_a);

   // C1: tolerance tests and products of the distance.
   logic                  vc1_ff, conc1_ff, eq1_ff, r0lt1_ff, ina1_ff, inb1_ff;
   logic [DSTW-1:0]       dist1_ff;
   logic [2*DSTW-1:0]     dsq1_ff;
   logic [TWDW-1:0]       twod1_ff;
   logic [R0TW-1:0]       r0tw1_ff;
   logic signed [DXW-1:0] dxc1_ff, dyc1_ff;
   logic [R2W-1:0]        r0sqc1_ff, r1sqc1_ff;

   // C2: r0^2 + dist^2.
   logic                  vc2_ff, conc2_ff, eq2_ff, r0lt2_ff, ina2_ff, inb2_ff;
   logic [NUMW-1:0]       pos2_ff;
   logic [DSTW-1:0]       dist2_ff;
   logic [TWDW-1:0]       twod2_ff;
   logic [R0TW-1:0]       r0tw2_ff;
   logic signed [DXW-1:0] dxc2_ff, dyc2_ff;
   logic [R2W-1:0]        r0sqc2_ff, r1sqc2_ff;

   // C3: chord numerator magnitude and sign.
   logic                  vc3_ff, conc3_ff, eq3_ff, r0lt3_ff, ina3_ff, inb3_ff;
   logic                  xneg3_ff;
   logic [NUMW-1:0]       num3_ff;
   logic [DSTW-1:0]       dist3_ff;
   logic [TWDW-1:0]       twod3_ff;
   logic [R0TW-1:0]       r0tw3_ff;
   logic signed [DXW-1:0] dxc3_ff, dyc3_ff;
   logic [R2W-1:0]        r0sqc3_ff;

   // C4: relation code.
   logic                  vc4_ff, xneg4_ff;
   rel_type               rel4_ff, rel4_in;
   logic [NUMW-1:0]       num4_ff;
   logic [DSTW-1:0]       dist4_ff;
   logic [TWDW-1:0]       twod4_ff;
   logic [DXW-1:0]        dxm4_ff, dym4_ff;
   logic signed [DXW-1:0] dxc4_ff, dyc4_ff;
   logic [R2W-1:0]        r0sqc4_ff;
   logic [DXW-1:0]        dxm3, dym3;
   logic                  nocross3;

   assign dxm3     = dxc3_ff[DXW-1] ? DXW'(-dxc3_ff) : DXW'(dxc3_ff);
   assign dym3     = dyc3_ff[DXW-1] ? DXW'(-dyc3_ff) : DXW'(dyc3_ff);
   assign nocross3 = num3_ff >= NUMW'(r0tw3_ff);

   always_comb begin
      if (conc3_ff) begin
         if (eq3_ff) begin
            rel4_in = REL_EQUAL;
         end else if (r0lt3_ff) begin
            rel4_in = REL_FIRST_INSIDE;
         end else begin
            rel4_in = REL_SECOND_INSIDE;
         end
      end else if (nocross3) begin
         if (ina3_ff) begin
            rel4_in = REL_FIRST_INSIDE;
         end else if (inb3_ff) begin
            rel4_in = REL_SECOND_INSIDE;
         end else begin
            rel4_in = REL_DISJOINT;
         end
      end else begin
         rel4_in = REL_INTERSECT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vc1_ff <= 1'b0;
         vc2_ff <= 1'b0;
         vc3_ff <= 1'b0;
         vc4_ff <= 1'b0;
      end else if (en) begin
         vc1_ff <= va;
         vc2_ff <= vc1_ff;
         vc3_ff <= vc2_ff;
         vc4_ff <= vc3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         conc1_ff  <= (dist_a < DSTW'(tol_ff)) || (dist_a == '0);
         eq1_ff    <= DXW'(rdiff_a) < DXW'(tol_ff);
         r0lt1_ff  <= r0_a < r1_a;
         ina1_ff   <= (TWDW'(r1_a) + TWDW'(tol_ff)) > (TWDW'(r0_a) + TWDW'(dist_a));
         inb1_ff   <= (TWDW'(r0_a) + TWDW'(tol_ff)) > (TWDW'(r1_a) + TWDW'(dist_a));
         dist1_ff  <= dist_a;
         dsq1_ff   <= dist_a * dist_a;
         twod1_ff  <= {dist_a, 1'b0};
         r0tw1_ff  <= r0_a * {dist_a, 1'b0};
         dxc1_ff   <= dx_a;
         dyc1_ff   <= dy_a;
         r0sqc1_ff <= r0sq_a;
         r1sqc1_ff <= r1sq_a;

         conc2_ff  <= conc1_ff;
         eq2_ff    <= eq1_ff;
         r0lt2_ff  <= r0lt1_ff;
         ina2_ff   <= ina1_ff;
         inb2_ff   <= inb1_ff;
         pos2_ff   <= NUMW'(r0sqc1_ff) + NUMW'(dsq1_ff);
         dist2_ff  <= dist1_ff;
         twod2_ff  <= twod1_ff;
         r0tw2_ff  <= r0tw1_ff;
         dxc2_ff   <= dxc1_ff;
         dyc2_ff   <= dyc1_ff;
         r0sqc2_ff <= r0sqc1_ff;
         r1sqc2_ff <= r1sqc1_ff;

         conc3_ff  <= conc2_ff;
         eq3_ff    <= eq2_ff;
         r0lt3_ff  <= r0lt2_ff;
         ina3_ff   <= ina2_ff;
         inb3_ff   <= inb2_ff;
         xneg3_ff  <= pos2_ff < NUMW'(r1sqc2_ff);
         num3_ff   <= (pos2_ff < NUMW'(r1sqc2_ff)) ? (NUMW'(r1sqc2_ff) - pos2_ff)
                                                   : (pos2_ff - NUMW'(r1sqc2_ff));
         dist3_ff  <= dist2_ff;
         twod3_ff  <= twod2_ff;
         r0tw3_ff  <= r0tw2_ff;
         dxc3_ff   <= dxc2_ff;
         dyc3_ff   <= dyc2_ff;
         r0sqc3_ff <= r0sqc2_ff;

         rel4_ff   <= rel4_in;
         xneg4_ff  <= xneg3_ff;
         num4_ff   <= num3_ff;
         dist4_ff  <= dist3_ff;
         twod4_ff  <= twod3_ff;
         dxm4_ff   <= dxm3;
         dym4_ff   <= dym3;
         dxc4_ff   <= dxc3_ff;
         dyc4_ff   <= dyc3_ff;
         r0sqc4_ff <= r0sqc3_ff;
      end
   end

   // ------------------------------------------------------------- dividers
   localparam int PBW = 3 + 1 + 2 * DXW + R2W;

   logic [QW-1:0]         xq_b, uxq_b, uyq_b;
   logic                  vb;
   logic [PBW-1:0]        pb_out;
   logic [2:0]            rel_b;
   logic                  xneg_b;
   logic signed [DXW-1:0] dx_b, dy_b;
   logic [R2W-1:0]        r0sq_b;

   cci_div #(.NW(NUMW), .DW(TWDW), .QW(QW)) u_x_div (
      .clock (clock),
      .en    (en),
      .num   (num4_ff),
      .den   (twod4_ff),
      .quo   (xq_b)
   );

   cci_div #(.NW(UNW), .DW(DSTW), .QW(QW)) u_ux_div (
      .clock (clock),
      .en    (en),
      .num   ({dxm4_ff, {F{1'b0}}}),
      .den   (dist4_ff),
      .quo   (uxq_b)
   );

   cci_div #(.NW(UNW), .DW(DSTW), .QW(QW)) u_uy_div (
      .clock (clock),
      .en    (en),
      .num   ({dym4_ff, {F{1'b0}}}),
      .den   (dist4_ff),
      .quo   (uyq_b)
   );

   cci_delay #(.DEPTH(QW), .W(PBW)) u_div_delay (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (vc4_ff),
      .in_data   ({rel4_ff, xneg4_ff, dxc4_ff, dyc4_ff, r0sqc4_ff}),
      .out_valid (vb),
      .out_data  (pb_out)
   );

   assign {rel_b, xneg_b, dx_b, dy_b, r0sq_b} = pb_out;

   // ------------------------------------------------------------ half chord
   logic [RRW-1:0] xm_b;
   logic [F:0]     uxm_b, uym_b;

   assign xm_b  = xq_b[RRW-1:0];
   assign uxm_b = uxq_b[F:0];
   assign uym_b = uyq_b[F:0];

   logic                  vy1_ff, vy2_ff;
   logic [2:0]            rely1_ff, rely2_ff;
   logic signed [DXW-1:0] dxy1_ff, dyy1_ff, dxy2_ff, dyy2_ff;
   logic [R2W-1:0]        r0sqy1_ff, xsqy1_ff, rady2_ff;
   logic signed [CW-1:0]  xvy1_ff, xvy2_ff;
   logic signed [UW-1:0]  uxy1_ff, uyy1_ff, uxy2_ff, uyy2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vy1_ff <= 1'b0;
         vy2_ff <= 1'b0;
      end else if (en) begin
         vy1_ff <= vb;
         vy2_ff <= vy1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rely1_ff  <= rel_b;
         dxy1_ff   <= dx_b;
         dyy1_ff   <= dy_b;
         r0sqy1_ff <= r0sq_b;
         xsqy1_ff  <= xm_b * xm_b;
         xvy1_ff   <= xneg_b ? -CW'(xm_b) : CW'(xm_b);
         uxy1_ff   <= dx_b[DXW-1] ? -UW'(uxm_b) : UW'(uxm_b);
         uyy1_ff   <= dy_b[DXW-1] ? -UW'(uym_b) : UW'(uym_b);

         rely2_ff  <= rely1_ff;
         dxy2_ff   <= dxy1_ff;
         dyy2_ff   <= dyy1_ff;
         rady2_ff  <= r0sqy1_ff - xsqy1_ff;
         xvy2_ff   <= xvy1_ff;
         uxy2_ff   <= uxy1_ff;
         uyy2_ff   <= uyy1_ff;
      end
   end

   localparam int PCW = 3 + 2 * DXW + CW + 2 * UW;

   logic [RRW-1:0]        y_c;
   logic                  vc;
   logic [PCW-1:0]        pc_out;
   logic [2:0]            rel_c;
   logic signed [DXW-1:0] dx_c, dy_c;
   logic signed [CW-1:0]  xv_c, yv_c;
   logic signed [UW-1:0]  ux_c, uy_c;

   cci_sqrt #(.NW(R2W), .RW(RRW)) u_y_sqrt (
      .clock (clock),
      .en    (en),
      .rad   (rady2_ff),
      .root  (y_c)
   );

   cci_delay #(.DEPTH(RRW), .W(PCW)) u_y_delay (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (vy2_ff),
      .in_data   ({rely2_ff, dxy2_ff, dyy2_ff, xvy2_ff, uxy2_ff, uyy2_ff}),
      .out_valid (vc),
      .out_data  (pc_out)
   );

   assign {rel_c, dx_c, dy_c, xv_c, ux_c, uy_c} = pc_out;
   assign yv_c = {1'b0, y_c};

   // -------------------------------------------------------------- rotation
   logic                  vr1_ff, vr2_ff;
   logic [2:0]            relr1_ff, relr2_ff;
   logic signed [DXW-1:0] dxr1_ff, dyr1_ff, dxr2_ff, dyr2_ff;
   logic signed [PRW-1:0] pxx_ff, pyy_ff, pyx_ff, pxy_ff;
   logic signed [SHW-1:0] a0x_ff, a0y_ff, b0x_ff, b0y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vr1_ff <= 1'b0;
         vr2_ff <= 1'b0;
      end else if (en) begin
         vr1_ff <= vc;
         vr2_ff <= vr1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         relr1_ff <= rel_c;
         dxr1_ff  <= dx_c;
         dyr1_ff  <= dy_c;
         pxx_ff   <= PRW'(ux_c) * PRW'(xv_c);
         pyy_ff   <= PRW'(uy_c) * PRW'(yv_c);
         pyx_ff   <= PRW'(uy_c) * PRW'(xv_c);
         pxy_ff   <= PRW'(ux_c) * PRW'(yv_c);

         relr2_ff <= relr1_ff;
         dxr2_ff  <= dxr1_ff;
         dyr2_ff  <= dyr1_ff;
         a0x_ff   <= SHW'((SUMW'(pxx_ff) - SUMW'(pyy_ff)) >>> F);
         a0y_ff   <= SHW'((SUMW'(pyx_ff) + SUMW'(pxy_ff)) >>> F);
         b0x_ff   <= SHW'((SUMW'(pxx_ff) + SUMW'(pyy_ff)) >>> F);
         b0y_ff   <= SHW'((SUMW'(pyx_ff) - SUMW'(pxy_ff)) >>> F);
      end
   end

   // --------------------------------------------------------- output stage
   logic          rsp_valid_ff;
   rel_type       rel_ff;
   logic [CW-1:0] p0ax_ff, p0ay_ff, p0bx_ff, p0by_ff;
   logic [CW-1:0] p1ax_ff, p1ay_ff, p1bx_ff, p1by_ff;
   logic          hit;

   assign hit = relr2_ff == REL_INTERSECT;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= vr2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rel_ff  <= rel_type'(relr2_ff);
         p0ax_ff <= hit ? sat(FW'(a0x_ff)) : '0;
         p0ay_ff <= hit ? sat(FW'(a0y_ff)) : '0;
         p0bx_ff <= hit ? sat(FW'(b0x_ff)) : '0;
         p0by_ff <= hit ? sat(FW'(b0y_ff)) : '0;
         p1ax_ff <= hit ? sat(FW'(FW'(b0x_ff) - FW'(dxr2_ff))) : '0;
         p1ay_ff <= hit ? sat(FW'(FW'(b0y_ff) - FW'(dyr2_ff))) : '0;
         p1bx_ff <= hit ? sat(FW'(FW'(a0x_ff) - FW'(dxr2_ff))) : '0;
         p1by_ff <= hit ? sat(FW'(FW'(a0y_ff) - FW'(dyr2_ff))) : '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({p1by_ff, p1bx_ff, p1ay_ff, p1ax_ff,
                               p0by_ff, p0bx_ff, p0ay_ff, p0ax_ff, rel_ff});

endmodule
